@@ hdl/ppc_pkg.sv @@
// Shared types, register indexes and reset values for the plane particle collision unit.
`default_nettype none
package ppc_pkg;

  typedef logic signed [31:0] q_t;

  // Input item: particle position, velocity and force, signed Q16.16
  typedef struct packed {
    q_t pos_x;
    q_t pos_y;
    q_t pos_z;
    q_t vel_in_x;
    q_t vel_in_y;
    q_t vel_in_z;
    q_t force_in_x;
    q_t force_in_y;
    q_t force_in_z;
  } in_item_t;

  // Result item
  typedef struct packed {
    q_t   vel_out_x;
    q_t   vel_out_y;
    q_t   vel_out_z;
    q_t   force_out_x;
    q_t   force_out_y;
    q_t   force_out_z;
    logic bounced;
    logic contact_applied;
  } out_item_t;

  // Register indexes (word address on the configuration port)
  typedef enum logic [2:0] {
    REG_PLANE_HEIGHT     = 3'd0,
    REG_PLANE_VERT_SPEED = 3'd1,
    REG_HOLE_CENTER_X    = 3'd2,
    REG_HOLE_CENTER_Z    = 3'd3,
    REG_GAP_RADIUS       = 3'd4,
    REG_RESTITUTION      = 3'd5,
    REG_FRICTION         = 3'd6,
    REG_CONTACT_MARGIN   = 3'd7
  } reg_idx_t;

  localparam logic [16:0] RESTITUTION_RST    = 17'd52429;
  localparam logic [16:0] FRICTION_RST       = 17'd13107;
  localparam logic [16:0] CONTACT_MARGIN_RST = 17'd655;

  // Current register contents
  typedef struct packed {
    q_t          plane_height;
    q_t          plane_vert_speed;
    q_t          hole_center_x;
    q_t          hole_center_z;
    logic [30:0] gap_radius;
    logic [16:0] restitution;
    logic [16:0] friction;
    logic [16:0] contact_margin;
  } cfg_t;

  // Item state handed from the product stages to the resolve stages
  typedef struct packed {
    q_t          vel_x;
    q_t          vel_y;
    q_t          vel_z;
    q_t          force_x;
    q_t          force_y;
    q_t          force_z;
    logic        far;
    logic [61:0] dx2;
    logic [61:0] dy2;
    logic [61:0] dz2;
    logic [61:0] r2;
    logic        in_contact;
    logic        approach;
    logic [49:0] bounce_prod;
    logic        fy_neg;
    logic        fric_x_neg;
    logic        fric_z_neg;
    logic [63:0] fric_px;
    logic [63:0] fric_pz;
  } mid_t;

endpackage
`default_nettype wire

@@ hdl/plane_particle_collision_unit.sv @@
// Top level of the plane particle collision unit: register file and four-stage pipeline.
// out_valid/out_data show a result once its item has passed through every register stage.
// Throughput: one particle per cycle while busy is low, since results are never held off;
//   four register stages (offsets, products, hole test and scaling, saturation).
// busy is high during reset and until the first clock edge after reset is released; otherwise it stays low.
// Reset clears all stage valid bits and loads the default register values.
`default_nettype none
module plane_particle_collision_unit (
  input  wire logic               clk,
  input  wire logic               rst_n,
  // item input
  input  wire logic               start,
  output logic                    busy,
  input  wire ppc_pkg::in_item_t  in_data,
  // result output
  output logic                    out_valid,
  output ppc_pkg::out_item_t      out_data,
  // configuration port
  input  wire logic               psel,
  input  wire logic               penable,
  input  wire logic               pwrite,
  input  wire logic [4:0]         paddr,
  input  wire logic [31:0]        pwdata,
  output logic [31:0]             prdata,
  output logic                    pready
);
  import ppc_pkg::*;

  cfg_t cfg;
  mid_t mid;
  logic mid_valid;
  logic busy_r;
  logic accept;

  // Hold off items only around reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b1;
    end else begin
      busy_r <= 1'b0;
    end
  end

  assign busy   = busy_r;
  assign accept = start & ~busy_r;

  ppc_regs u_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  ppc_prep u_prep (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (accept),
    .in_item   (in_data),
    .cfg       (cfg),
    .mid_valid (mid_valid),
    .mid       (mid)
  );

  ppc_resolve u_resolve (
    .clk       (clk),
    .rst_n     (rst_n),
    .mid_valid (mid_valid),
    .mid       (mid),
    .cfg       (cfg),
    .out_valid (out_valid),
    .out_item  (out_data)
  );

endmodule
`default_nettype wire

@@ hdl/ppc_regs.sv @@
// APB register file holding the plane, hole and coefficient settings.
`default_nettype none
module ppc_regs (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [4:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready,
  output ppc_pkg::cfg_t    cfg
);
  import ppc_pkg::*;

  cfg_t     cfg_r;
  cfg_t     cfg_nxt;
  reg_idx_t idx;
  logic     wr_en;

  assign idx    = reg_idx_t'(paddr[4:2]);
  assign wr_en  = psel & penable & pwrite;
  assign pready = 1'b1;
  assign cfg    = cfg_r;

  // Decode a write into the next register image
  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      case (idx)
        REG_PLANE_HEIGHT:     cfg_nxt.plane_height     = pwdata;
        REG_PLANE_VERT_SPEED: cfg_nxt.plane_vert_speed = pwdata;
        REG_HOLE_CENTER_X:    cfg_nxt.hole_center_x    = pwdata;
        REG_HOLE_CENTER_Z:    cfg_nxt.hole_center_z    = pwdata;
        REG_GAP_RADIUS:       cfg_nxt.gap_radius       = pwdata[30:0];
        REG_RESTITUTION:      cfg_nxt.restitution      = pwdata[16:0];
        REG_FRICTION:         cfg_nxt.friction         = pwdata[16:0];
        REG_CONTACT_MARGIN:   cfg_nxt.contact_margin   = pwdata[16:0];
        default:              cfg_nxt = cfg_r;
      endcase
    end
  end

  // Hold the registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.plane_height     <= '0;
      cfg_r.plane_vert_speed <= '0;
      cfg_r.hole_center_x    <= '0;
      cfg_r.hole_center_z    <= '0;
      cfg_r.gap_radius       <= '0;
      cfg_r.restitution      <= RESTITUTION_RST;
      cfg_r.friction         <= FRICTION_RST;
      cfg_r.contact_margin   <= CONTACT_MARGIN_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  // Read back the addressed register
  always_comb begin
    case (idx)
      REG_PLANE_HEIGHT:     prdata = cfg_r.plane_height;
      REG_PLANE_VERT_SPEED: prdata = cfg_r.plane_vert_speed;
      REG_HOLE_CENTER_X:    prdata = cfg_r.hole_center_x;
      REG_HOLE_CENTER_Z:    prdata = cfg_r.hole_center_z;
      REG_GAP_RADIUS:       prdata = {1'b0, cfg_r.gap_radius};
      REG_RESTITUTION:      prdata = {15'd0, cfg_r.restitution};
      REG_FRICTION:         prdata = {15'd0, cfg_r.friction};
      REG_CONTACT_MARGIN:   prdata = {15'd0, cfg_r.contact_margin};
      default:              prdata = '0;
    endcase
  end

endmodule
`default_nettype wire

@@ hdl/ppc_prep.sv @@
// Front stages: offsets and magnitudes, then the squares and products of each item.
`default_nettype none
module ppc_prep (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  input  wire ppc_pkg::in_item_t in_item,
  input  wire ppc_pkg::cfg_t     cfg,
  output logic                   mid_valid,
  output ppc_pkg::mid_t          mid
);
  import ppc_pkg::*;

  // Stage 1 registers
  logic        s1_valid_r;
  in_item_t    s1_item_r;
  logic [32:0] s1_dx_r, s1_dy_r, s1_dz_r;
  logic [32:0] s1_ydiff_r;
  logic [32:0] s1_rel_r;
  logic [31:0] s1_fy_mag_r, s1_vx_mag_r, s1_vz_mag_r;

  // Stage 2 registers
  logic        mid_valid_r;
  mid_t        mid_r;
  mid_t        mid_nxt;

  // Stage 1 combinational values
  logic [32:0] dx_raw, dy_raw, dz_raw, rel_raw;

  // Stage 2 combinational values
  logic [33:0] cm_ext;
  logic [33:0] ydiff_less_cm;
  logic [33:0] rel_plus_cm;
  logic [32:0] rel_mag;

  function automatic logic [32:0] mag33(input logic [32:0] v);
    mag33 = v[32] ? (~v + 33'd1) : v;
  endfunction

  function automatic logic [31:0] mag32(input logic [31:0] v);
    mag32 = v[31] ? (~v + 32'd1) : v;
  endfunction

  // Form the offsets from the hole center and the plane, and the relative speed
  assign dx_raw  = {in_item.pos_x[31], in_item.pos_x} -
                   {cfg.hole_center_x[31], cfg.hole_center_x};
  assign dy_raw  = {in_item.pos_y[31], in_item.pos_y} -
                   {cfg.plane_height[31], cfg.plane_height};
  assign dz_raw  = {in_item.pos_z[31], in_item.pos_z} -
                   {cfg.hole_center_z[31], cfg.hole_center_z};
  assign rel_raw = {in_item.vel_in_y[31], in_item.vel_in_y} -
                   {cfg.plane_vert_speed[31], cfg.plane_vert_speed};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= in_valid;
    end
  end

  // Capture the item with its offsets
  always_ff @(posedge clk) begin
    if (in_valid) begin
      s1_item_r   <= in_item;
      s1_dx_r     <= mag33(dx_raw);
      s1_dy_r     <= mag33(dy_raw);
      s1_dz_r     <= mag33(dz_raw);
      s1_ydiff_r  <= dy_raw;
      s1_rel_r    <= rel_raw;
      s1_fy_mag_r <= mag32(in_item.force_in_y);
      s1_vx_mag_r <= mag32(in_item.vel_in_x);
      s1_vz_mag_r <= mag32(in_item.vel_in_z);
    end
  end

  // Compare against the margin and form the squares and products
  assign cm_ext        = {17'd0, cfg.contact_margin};
  assign ydiff_less_cm = {s1_ydiff_r[32], s1_ydiff_r} - cm_ext;
  assign rel_plus_cm   = {s1_rel_r[32], s1_rel_r} + cm_ext;
  assign rel_mag       = mag33(s1_rel_r);

  always_comb begin
    mid_nxt.vel_x       = s1_item_r.vel_in_x;
    mid_nxt.vel_y       = s1_item_r.vel_in_y;
    mid_nxt.vel_z       = s1_item_r.vel_in_z;
    mid_nxt.force_x     = s1_item_r.force_in_x;
    mid_nxt.force_y     = s1_item_r.force_in_y;
    mid_nxt.force_z     = s1_item_r.force_in_z;
    mid_nxt.far         = s1_dx_r[32] | s1_dx_r[31] | s1_dy_r[32] | s1_dy_r[31] |
                          s1_dz_r[32] | s1_dz_r[31];
    mid_nxt.dx2         = {31'd0, s1_dx_r[30:0]} * {31'd0, s1_dx_r[30:0]};
    mid_nxt.dy2         = {31'd0, s1_dy_r[30:0]} * {31'd0, s1_dy_r[30:0]};
    mid_nxt.dz2         = {31'd0, s1_dz_r[30:0]} * {31'd0, s1_dz_r[30:0]};
    mid_nxt.r2          = {31'd0, cfg.gap_radius} * {31'd0, cfg.gap_radius};
    mid_nxt.in_contact  = ydiff_less_cm[33];
    mid_nxt.approach    = rel_plus_cm[33];
    mid_nxt.bounce_prod = {17'd0, rel_mag} * {33'd0, cfg.restitution};
    mid_nxt.fy_neg      = s1_item_r.force_in_y[31];
    mid_nxt.fric_x_neg  = s1_item_r.force_in_y[31] ^ s1_item_r.vel_in_x[31];
    mid_nxt.fric_z_neg  = s1_item_r.force_in_y[31] ^ s1_item_r.vel_in_z[31];
    mid_nxt.fric_px     = {32'd0, s1_fy_mag_r} * {32'd0, s1_vx_mag_r};
    mid_nxt.fric_pz     = {32'd0, s1_fy_mag_r} * {32'd0, s1_vz_mag_r};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mid_valid_r <= 1'b0;
    end else begin
      mid_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_valid_r) begin
      mid_r <= mid_nxt;
    end
  end

  assign mid_valid = mid_valid_r;
  assign mid       = mid_r;

endmodule
`default_nettype wire

@@ hdl/ppc_resolve.sv @@
// Back stages: hole test, bounce and friction scaling, then the saturated result item.
`default_nettype none
module ppc_resolve (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           mid_valid,
  input  wire ppc_pkg::mid_t  mid,
  input  wire ppc_pkg::cfg_t  cfg,
  output logic                out_valid,
  output ppc_pkg::out_item_t  out_item
);
  import ppc_pkg::*;

  // Stage 3 registers
  logic        s3_valid_r;
  q_t          s3_vel_x_r, s3_vel_y_r, s3_vel_z_r;
  q_t          s3_force_x_r, s3_force_y_r, s3_force_z_r;
  logic        s3_bounce_r, s3_apply_r;
  logic [34:0] s3_mb_r;
  logic [48:0] s3_phf_x_r, s3_plf_x_r, s3_phf_z_r, s3_plf_z_r;
  logic        s3_neg_x_r, s3_neg_z_r;

  // Stage 4 (output) registers
  logic        out_valid_r;
  out_item_t   out_r;
  out_item_t   out_nxt;

  // Stage 3 combinational values
  logic [63:0] dist2;
  logic        outside;
  logic        touching;
  logic [50:0] mb_sum;

  // Stage 4 combinational values
  logic [49:0] rnd_x, rnd_z;
  logic [49:0] mx, mz;
  logic [51:0] fx_sum, fz_sum;

  function automatic q_t sat52(input logic [51:0] v);
    if (!v[51] && (v[50:31] != 20'd0)) begin
      sat52 = 32'h7FFF_FFFF;
    end else if (v[51] && (v[50:31] != 20'hF_FFFF)) begin
      sat52 = 32'h8000_0000;
    end else begin
      sat52 = v[31:0];
    end
  endfunction

  function automatic logic [51:0] add_mag(input q_t base, input logic [49:0] m,
                                          input logic neg);
    logic [51:0] b;
    b = {{20{base[31]}}, base};
    add_mag = neg ? (b - {2'd0, m}) : (b + {2'd0, m});
  endfunction

  // Decide hole, contact and bounce; round the bounce speed
  assign dist2    = {2'd0, mid.dx2} + {2'd0, mid.dy2} + {2'd0, mid.dz2};
  assign outside  = mid.far | (dist2 >= {2'd0, mid.r2});
  assign touching = outside & mid.in_contact;
  assign mb_sum   = {1'b0, mid.bounce_prod} + 51'd32768;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_valid_r <= 1'b0;
    end else begin
      s3_valid_r <= mid_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (mid_valid) begin
      s3_vel_x_r   <= mid.vel_x;
      s3_vel_y_r   <= mid.vel_y;
      s3_vel_z_r   <= mid.vel_z;
      s3_force_x_r <= mid.force_x;
      s3_force_y_r <= mid.force_y;
      s3_force_z_r <= mid.force_z;
      s3_bounce_r  <= touching & mid.approach;
      s3_apply_r   <= touching & mid.fy_neg;
      s3_mb_r      <= mb_sum[50:16];
      s3_phf_x_r   <= {17'd0, mid.fric_px[63:32]} * {32'd0, cfg.friction};
      s3_plf_x_r   <= {17'd0, mid.fric_px[31:0]} * {32'd0, cfg.friction};
      s3_phf_z_r   <= {17'd0, mid.fric_pz[63:32]} * {32'd0, cfg.friction};
      s3_plf_z_r   <= {17'd0, mid.fric_pz[31:0]} * {32'd0, cfg.friction};
      s3_neg_x_r   <= mid.fric_x_neg;
      s3_neg_z_r   <= mid.fric_z_neg;
    end
  end

  // Finish the friction terms and saturate the result item
  assign rnd_x  = {1'b0, s3_plf_x_r} + 50'h0_8000_0000;
  assign rnd_z  = {1'b0, s3_plf_z_r} + 50'h0_8000_0000;
  assign mx     = {1'b0, s3_phf_x_r} + {32'd0, rnd_x[49:32]};
  assign mz     = {1'b0, s3_phf_z_r} + {32'd0, rnd_z[49:32]};
  assign fx_sum = add_mag(s3_force_x_r, mx, s3_neg_x_r);
  assign fz_sum = add_mag(s3_force_z_r, mz, s3_neg_z_r);

  always_comb begin
    out_nxt.vel_out_x       = s3_vel_x_r;
    out_nxt.vel_out_z       = s3_vel_z_r;
    out_nxt.vel_out_y       = s3_vel_y_r;
    out_nxt.force_out_x     = s3_force_x_r;
    out_nxt.force_out_y     = s3_force_y_r;
    out_nxt.force_out_z     = s3_force_z_r;
    out_nxt.bounced         = s3_bounce_r;
    out_nxt.contact_applied = s3_apply_r;
    if (s3_bounce_r) begin
      out_nxt.vel_out_y = (s3_mb_r[34:31] != 4'd0) ? 32'h7FFF_FFFF : {1'b0, s3_mb_r[30:0]};
    end
    if (s3_apply_r) begin
      out_nxt.force_out_y = '0;
      out_nxt.force_out_x = sat52(fx_sum);
      out_nxt.force_out_z = sat52(fz_sum);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= s3_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s3_valid_r) begin
      out_r <= out_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_r;

endmodule
`default_nettype wire
